>>> rtl/kvt_pkg.sv
// Package for the key/value table: sizes, action codes and the word types
// that pass between the front queue, the scan engine and the ports.
// No dependencies.
package kvt_pkg;

    localparam int CAPACITY  = 16;
    localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ACT_W     = 2;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int ENTRIES_W = 5;

    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] old_value;
        logic                    full_res;
        logic [ENTRIES_W-1:0]    entries;
    } rsp_t;

    // Classified operation as it waits for the scan engine
    typedef struct packed {
        logic                    lookup;
        logic                    is_add;
        logic                    is_remove;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

endpackage

>>> rtl/kvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/kvt_front.sv
// Front end of the key/value table: accepts request words, decodes the
// action and holds up to two classified commands for the scan engine.
// Depends on kvt_pkg.
module kvt_front
    import kvt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t req,
    output logic full,
    output logic cmd_valid,
    output cmd_t cmd,
    input  logic cmd_pop
);

    localparam int QDEPTH = 2;

    cmd_t       q_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;
    cmd_t       cls;

    // Decode the action; the unused code matches nothing and changes nothing
    always_comb
    begin
        cls           = '0;
        cls.key       = req.key;
        cls.value     = req.value;
        unique case (req.action)
            ACT_ADD:
            begin
                cls.lookup = 1'b1;
                cls.is_add = 1'b1;
            end
            ACT_SEARCH:
            begin
                cls.lookup = 1'b1;
            end
            ACT_REMOVE:
            begin
                cls.lookup    = 1'b1;
                cls.is_remove = 1'b1;
            end
            default:
            begin
                cls.lookup = 1'b0;
            end
        endcase
    end

    assign full      = (cnt_reg == 2'(QDEPTH));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> rtl/kvt_engine.sv
// Scan engine of the key/value table: walks every slot of the key/value RAM
// for a key match and the lowest free slot, then writes back and reports.
// Depends on kvt_pkg and kvt_ram.
module kvt_engine
    import kvt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic rsp_valid,
    output rsp_t rsp,
    input  logic rsp_pop
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    localparam int ENT_W = KEY_W + VAL_W;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [CNT_W-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                    cmp_live_reg, cmp_live_next;
    logic [SLOT_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                    hit_reg, hit_next;
    logic [SLOT_W-1:0]       hit_idx_reg, hit_idx_next;
    logic signed [VAL_W-1:0] hit_val_reg, hit_val_next;
    logic                    free_reg, free_next;
    logic [SLOT_W-1:0]       free_idx_reg, free_idx_next;
    logic                    slot_valid_reg [CAPACITY];
    logic                    slot_valid_next [CAPACITY];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    logic                    ram_we, ram_re;
    logic [SLOT_W-1:0]       ram_waddr, ram_raddr;
    logic [ENT_W-1:0]        ram_wdata, ram_rdata;
    logic [KEY_W-1:0]        rd_key;
    logic [VAL_W-1:0]        rd_val;
    logic                    start;

    kvt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[ENT_W-1:VAL_W];
    assign rd_val    = ram_rdata[VAL_W-1:0];
    assign ram_raddr = scan_cnt_reg[SLOT_W-1:0];
    assign ram_wdata = {cmd_reg.key, cmd_reg.value};
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_live_next   = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_val_next    = hit_val_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        slot_valid_next = slot_valid_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_pop;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = hit_reg ? hit_idx_reg : free_idx_reg;
        start           = 1'b0;

        // Compare the slot read in the previous cycle
        if (cmp_live_reg)
        begin
            if (cmd_reg.lookup && slot_valid_reg[cmp_idx_reg]
                && rd_key == cmd_reg.key && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx_reg;
                hit_val_next = rd_val;
            end
            if (!slot_valid_reg[cmp_idx_reg] && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                start = cmd_valid;
            end
            S_SCAN:
            begin
                if (scan_cnt_reg != CNT_W'(CAPACITY))
                begin
                    ram_re        = 1'b1;
                    cmp_live_next = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[SLOT_W-1:0];
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Hold until the result register is free
                if (!rsp_valid_reg || rsp_pop)
                begin
                    rsp_next           = '0;
                    rsp_next.found     = hit_reg;
                    rsp_next.old_value = hit_reg ? hit_val_reg : '0;
                    if (cmd_reg.is_add)
                    begin
                        if (hit_reg)
                        begin
                            ram_we = 1'b1;
                        end
                        else if (free_reg)
                        begin
                            ram_we                        = 1'b1;
                            slot_valid_next[free_idx_reg] = 1'b1;
                            count_next                    = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            rsp_next.full_res = 1'b1;
                        end
                    end
                    else if (cmd_reg.is_remove && hit_reg)
                    begin
                        slot_valid_next[hit_idx_reg] = 1'b0;
                        count_next                   = count_reg - CNT_W'(1);
                    end
                    rsp_next.entries = ENTRIES_W'(count_next);
                    rsp_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                    start            = cmd_valid;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (start)
        begin
            cmd_next      = cmd;
            scan_cnt_next = '0;
            hit_next      = 1'b0;
            free_next     = 1'b0;
            state_next    = S_SCAN;
        end
    end

    assign cmd_pop = start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            cmp_live_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_live_reg   <= cmp_live_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_val_reg  <= hit_val_next;
        free_idx_reg <= free_idx_next;
        rsp_reg      <= rsp_next;
    end

endmodule

>>> rtl/key_value_table_core.sv
// Key/value table, top level. The engine works on one request at a time and
// takes the next only when it finishes the last; each request costs a full
// scan of the RAM at one slot per cycle, and finishing waits for a free result register.
// Two requests queue in front while the engine works and a result waits.
// Reset clears the slot valid bits, the entry count and both queues at once.
module key_value_table_core
    import kvt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t req,
    output logic full,
    output logic empty,
    output rsp_t rsp,
    input  logic pop
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic rsp_valid;

    kvt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .req       (req),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    kvt_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rsp_pop   (pop && rsp_valid)
    );

    assign empty = !rsp_valid;

`ifndef NO_ASSERTIONS
    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("engine took a command from an empty queue");

    a_refused_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.full_res) |-> !rsp.found)
        else $error("refused add reports a found key");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !rsp.found) |-> (rsp.old_value == '0))
        else $error("missing key reports a nonzero old value");

    a_refused_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.full_res) |-> (rsp.entries == ENTRIES_W'(CAPACITY)))
        else $error("add refused while the table has a free slot");
`endif

endmodule

>>> dv/key_value_table_core_test.sv
// Self-checking test of key_value_table_core: add, search, remove and unused-action words with
// random idling on both queue ports, checked against a table model kept here.
// Depends on kvt_pkg and the key_value_table_core RTL.
module key_value_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kvt_pkg::*;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_SIZE    = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    req_t req = '0;
    rsp_t rsp;
    logic full;
    logic empty;

    // table model state
    bit                slot_used [CAPACITY];
    logic [KEY_W-1:0]  slot_key [CAPACITY];
    logic [VAL_W-1:0]  slot_val [CAPACITY];
    int unsigned       live_count = 0;

    rsp_t              pending_results [$];
    int                error_count = 0;
    int                stall_left = 0;
    int                quiet_cycles = 0;
    bit                idle_on = 1'b1;
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];

    key_value_table_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .req   (req),
        .full  (full),
        .empty (empty),
        .rsp   (rsp),
        .pop   (pop)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic req_t table_op(logic [ACT_W-1:0] action, logic [KEY_W-1:0] key,
                                      logic [VAL_W-1:0] value);
        req_t w;
        w.action = action;
        w.key    = key;
        w.value  = value;
        return w;
    endfunction

    // Apply one operation to the model table and return the word it should produce.
    function automatic rsp_t predict_table_op(req_t w);
        rsp_t r;
        int hit;
        int free_slot;
        r = '0;
        hit = -1;
        free_slot = -1;
        if (w.action inside {ACT_ADD, ACT_SEARCH, ACT_REMOVE})
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (slot_used[i] && slot_key[i] == w.key && hit < 0)
                    hit = i;
                if (!slot_used[i] && free_slot < 0)
                    free_slot = i;
            end
        end
        if (hit >= 0)
        begin
            r.found     = 1'b1;
            r.old_value = slot_val[hit];
        end
        case (w.action)
            ACT_ADD:
            begin
                if (hit >= 0)
                    slot_val[hit] = w.value;
                else if (free_slot < 0)
                    r.full_res = 1'b1;
                else
                begin
                    slot_used[free_slot] = 1'b1;
                    slot_key[free_slot]  = w.key;
                    slot_val[free_slot]  = w.value;
                    live_count++;
                end
            end
            ACT_REMOVE:
            begin
                if (hit >= 0)
                begin
                    slot_used[hit] = 1'b0;
                    live_count--;
                end
            end
            default: ;
        endcase
        r.entries = live_count[ENTRIES_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task automatic check_result(rsp_t got);
        rsp_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result word with nothing pending", got.old_value, '0);
            return;
        end
        want = pending_results.pop_front();
        if (got.found !== want.found)
            report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.old_value !== want.old_value)
            report_mismatch("old_value", got.old_value, want.old_value);
        if (got.full_res !== want.full_res)
            report_mismatch("full_res", 32'(got.full_res), 32'(want.full_res));
        if (got.entries !== want.entries)
            report_mismatch("entries", 32'(got.entries), 32'(want.entries));
    endtask

    // Push one word; push stays high after acceptance so the next word can follow at once.
    task automatic send_table_op(req_t w);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        push <= 1'b1;
        req  <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(predict_table_op(w));
    endtask

    task automatic run_random_ops(int count, int add_pct, int search_pct, int remove_pct);
        int pick;
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < add_pct)
                action = ACT_ADD;
            else if (pick < add_pct + search_pct)
                action = ACT_SEARCH;
            else if (pick < add_pct + search_pct + remove_pct)
                action = ACT_REMOVE;
            else
                action = ACT_NONE;
            // mostly pool keys so hits, replaces and refusals happen; the rest is noise
            if ($urandom_range(0, 99) < 85)
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                key = $urandom;
            send_table_op(table_op(action, key, $urandom));
        end
    endtask

    task automatic test_directed_cases();
        send_table_op(table_op(ACT_SEARCH, 32'h1234_5678, 32'h0));
        send_table_op(table_op(ACT_REMOVE, 32'h1234_5678, 32'h0));
        send_table_op(table_op(ACT_NONE, 32'h1234_5678, 32'hFFFF_FFFF));
        send_table_op(table_op(ACT_ADD, 32'h8000_0000, 32'h7FFF_FFFF));
        send_table_op(table_op(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000));
        send_table_op(table_op(ACT_ADD, 32'h0000_0000, 32'hFFFF_FFFF));
        send_table_op(table_op(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0000));
        send_table_op(table_op(ACT_ADD, 32'h8000_0000, 32'h0000_0000));
        send_table_op(table_op(ACT_SEARCH, 32'h7FFF_FFFF, 32'h1));
        send_table_op(table_op(ACT_REMOVE, 32'h0000_0000, 32'h0));
        // fill the hole and the rest of the table
        for (int i = 0; i < CAPACITY - 3; i++)
            send_table_op(table_op(ACT_ADD, 32'h0000_1000 + i, ~i));
        send_table_op(table_op(ACT_ADD, 32'h5A5A_5A5A, 32'h1111_1111));
        send_table_op(table_op(ACT_ADD, 32'hFFFF_FFFF, 32'h5555_5555));
        send_table_op(table_op(ACT_NONE, 32'hFFFF_FFFF, 32'h0));
        send_table_op(table_op(ACT_REMOVE, 32'h0000_1005, 32'h0));
        send_table_op(table_op(ACT_SEARCH, 32'h0000_1006, 32'h0));
    endtask

    task automatic test_random_churn();
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        run_random_ops(550, 45, 25, 25);
    endtask

    task automatic test_full_table_pressure();
        run_random_ops(350, 70, 20, 8);
    endtask

    // Hold the sender until every pending word has come back, then run a remove-heavy burst.
    task automatic test_drain_pause();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        run_random_ops(150, 15, 25, 55);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        run_random_ops(320, 40, 30, 27);
    endtask

    // Result side: check the word at each pop, then decide whether to stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (pop && !empty)
                check_result(rsp);
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_churn();
        test_full_table_pressure();
        test_drain_pause();
        test_back_to_back();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
